### rtl/lvmrl_pkg.sv
package lvmrl_pkg;

    localparam int ID_W      = 29;
    localparam int LEN_W     = 4;
    localparam int WORD_W    = 32;
    localparam int GAP_W     = 16;
    localparam int STATUS_W  = 3;
    localparam int OUT_ID_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 29;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT0_ID  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT0_GAP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE  = 3'd6;
    localparam int                   ID_REG_COUNT  = 3;

    // item kinds
    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_TX    = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_QUEUED    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_UNKNOWN   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_RATE_DROP = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_SENT      = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOTHING   = 3'd4;

    localparam logic [ID_W-1:0] SCALED_ID   = 29'd933;
    localparam logic [6:0]      SCALE_MUL   = 7'd100;
    localparam logic [15:0]     SCALE_LIMIT = 16'hFFFF;
    localparam logic [LEN_W-1:0] SCALE_MIN_LEN = 4'd2;

    typedef struct packed {
        logic [OUT_ID_W-1:0] id;
        logic [LEN_W-1:0]    len;
        logic [WORD_W-1:0]   payload_lo;
        logic [WORD_W-1:0]   payload_hi;
        logic [WORD_W-1:0]   seq;
        logic [WORD_W-1:0]   last_ms;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

### rtl/lvmrl_ifs.sv
interface lvmrl_req_if
    import lvmrl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [ID_W-1:0]   frame_id;
    logic [LEN_W-1:0]  frame_len;
    logic [WORD_W-1:0] payload_lo;
    logic [WORD_W-1:0] payload_hi;
    logic [WORD_W-1:0] now_ms;

    modport source (output valid, req_type, frame_id, frame_len, payload_lo, payload_hi,
                    now_ms, input ready);
    modport sink   (input valid, req_type, frame_id, frame_len, payload_lo, payload_hi,
                    now_ms, output ready);
endinterface

interface lvmrl_rsp_if
    import lvmrl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [OUT_ID_W-1:0] out_id;
    logic [LEN_W-1:0]    out_len;
    logic [WORD_W-1:0]   out_payload_lo;
    logic [WORD_W-1:0]   out_payload_hi;
    logic [WORD_W-1:0]   out_seq;
    logic                out_fresh;

    modport source (output valid, status, out_id, out_len, out_payload_lo, out_payload_hi,
                    out_seq, out_fresh, input ready);
    modport sink   (input valid, status, out_id, out_len, out_payload_lo, out_payload_hi,
                    out_seq, out_fresh, output ready);
endinterface

interface lvmrl_cfg_if
    import lvmrl_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/lvmrl_ram.sv
module lvmrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/latest_value_mailbox_rate_limiter.sv
// Latest-value mailbox with per-slot rate limiting and round-robin transmit.
// Channels: req takes items (req_type 0 is a received frame, 1 a transmit
// request), rsp returns exactly one result item per request item, cfg
// writes the slot identifiers, per-slot minimum gaps and the throttle bit;
// cfg is always ready; the user must write it only while the block is idle, which the block does not enforce.
// Each slot's stored frame, sequence number and last accept time sit in
// one slot memory with a registered read port; pending and holds-data bits
// are flip-flops. An item is accepted in the idle state, its slot entry is
// read at the accept edge, and the update step then checks the rate and
// writes the entry for a frame, or reads out the stored entry for a
// transmit request, and loads the result register; rsp.valid rises as it
// commits. No new item is taken until then: slot memory is read, then written back.
// When rsp stalls, the finished result holds in the output register and the
// block waits in the update step without committing until the register
// frees; no further item is taken meanwhile.
// Reset clears pending and holds-data bits, the sequence counter, the round
// robin pointer and the configuration (throttle on); no clearing pass runs.
module latest_value_mailbox_rate_limiter
    import lvmrl_pkg::*;
#(
    parameter int SLOT_COUNT = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    lvmrl_req_if.sink   req,
    lvmrl_rsp_if.source rsp,
    lvmrl_cfg_if.sink   cfg
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RESP = 1'b1;

    logic state_reg, state_next;

    logic [ID_W-1:0]  slot_id_reg  [SLOT_COUNT];
    logic [GAP_W-1:0] slot_gap_reg [SLOT_COUNT];
    logic             throttle_reg;

    logic [SLOT_COUNT-1:0] pending_reg, pending_next;
    logic [SLOT_COUNT-1:0] holds_reg, holds_next;
    logic [WORD_W-1:0]     seq_reg, seq_next;
    logic [SW-1:0]         rr_reg, rr_next;

    logic              item_type_reg;
    logic [ID_W-1:0]   item_id_reg;
    logic [LEN_W-1:0]  item_len_reg;
    logic [WORD_W-1:0] item_lo_reg;
    logic [WORD_W-1:0] item_hi_reg;
    logic [WORD_W-1:0] item_now_reg;
    logic [SW-1:0]     slot_reg;
    logic              hit_reg;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [OUT_ID_W-1:0] out_id_reg, out_id_next;
    logic [LEN_W-1:0]    out_len_reg, out_len_next;
    logic [WORD_W-1:0]   out_lo_reg, out_lo_next;
    logic [WORD_W-1:0]   out_hi_reg, out_hi_next;
    logic [WORD_W-1:0]   out_seq_reg, out_seq_next;
    logic                out_fresh_reg, out_fresh_next;

    logic        accept;
    logic        commit;
    logic        match_hit;
    logic [SW-1:0] match_slot;
    logic [SW-1:0] rd_addr;

    logic        ram_we;
    slot_entry_t ram_wdata;
    slot_entry_t ram_rdata;

    logic [WORD_W-1:0] last_ms;
    logic [WORD_W-1:0] elapsed;
    logic              rate_ok;
    logic [22:0]       scaled;
    logic [15:0]       scaled_sat;
    logic [WORD_W-1:0] store_lo;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign commit    = (state_reg == S_RESP) && (!out_valid_reg || rsp.ready);
    assign cfg.ready = 1'b1;

    // lowest matching slot wins
    always_comb
    begin
        match_hit  = 1'b0;
        match_slot = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (slot_id_reg[i] == req.frame_id)
            begin
                match_hit  = 1'b1;
                match_slot = SW'(i);
            end
        end
    end

    assign rd_addr = (req.req_type == REQ_TX) ? rr_reg : match_slot;

    lvmrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_id_reg[i]  <= '0;
                slot_gap_reg[i] <= '0;
            end
            throttle_reg <= 1'b1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (i < ID_REG_COUNT && cfg.index == CFG_IDX_W'(CFG_SLOT0_ID + i))
                begin
                    slot_id_reg[i] <= cfg.data;
                end
                if (i < ID_REG_COUNT && cfg.index == CFG_IDX_W'(CFG_SLOT0_GAP + i))
                begin
                    slot_gap_reg[i] <= cfg.data[GAP_W-1:0];
                end
            end
            if (cfg.index == CFG_THROTTLE)
            begin
                throttle_reg <= cfg.data[0];
            end
        end
    end

    // rate check on the entry read back, and scaling of the new frame's payload
    always_comb
    begin
        last_ms    = holds_reg[slot_reg] ? ram_rdata.last_ms : '0;
        elapsed    = item_now_reg - last_ms;
        rate_ok    = !throttle_reg || (elapsed >= WORD_W'(slot_gap_reg[slot_reg]));
        scaled     = 23'(item_lo_reg[15:0]) * 23'(SCALE_MUL);
        scaled_sat = (scaled > 23'(SCALE_LIMIT)) ? SCALE_LIMIT : scaled[15:0];
        store_lo   = item_lo_reg;
        if (item_id_reg == SCALED_ID && item_len_reg >= SCALE_MIN_LEN)
        begin
            store_lo = {item_lo_reg[31:16], scaled_sat};
        end
        ram_wdata.id         = item_id_reg[OUT_ID_W-1:0];
        ram_wdata.len        = item_len_reg;
        ram_wdata.payload_lo = store_lo;
        ram_wdata.payload_hi = item_hi_reg;
        ram_wdata.seq        = seq_reg;
        ram_wdata.last_ms    = item_now_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        pending_next    = pending_reg;
        holds_next      = holds_reg;
        seq_next        = seq_reg;
        rr_next         = rr_reg;
        ram_we          = 1'b0;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_len_next    = out_len_reg;
        out_lo_next     = out_lo_reg;
        out_hi_next     = out_hi_reg;
        out_seq_next    = out_seq_reg;
        out_fresh_next  = out_fresh_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RESP;
                    if (req.req_type == REQ_TX)
                    begin
                        rr_next = (rr_reg >= LAST_SLOT) ? '0 : rr_reg + 1'b1;
                    end
                end
            end
            S_RESP:
            begin
                if (commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_id_next    = '0;
                    out_len_next   = '0;
                    out_lo_next    = '0;
                    out_hi_next    = '0;
                    out_seq_next   = '0;
                    out_fresh_next = 1'b0;
                    if (item_type_reg == REQ_FRAME)
                    begin
                        if (!hit_reg)
                        begin
                            out_status_next = STAT_UNKNOWN;
                        end
                        else if (!rate_ok)
                        begin
                            out_status_next = STAT_RATE_DROP;
                        end
                        else
                        begin
                            out_status_next        = STAT_QUEUED;
                            ram_we                 = 1'b1;
                            seq_next               = seq_reg + 1'b1;
                            holds_next[slot_reg]   = 1'b1;
                            pending_next[slot_reg] = 1'b1;
                        end
                    end
                    else if (holds_reg[slot_reg])
                    begin
                        out_status_next        = STAT_SENT;
                        out_id_next            = ram_rdata.id;
                        out_len_next           = ram_rdata.len;
                        out_lo_next            = ram_rdata.payload_lo;
                        out_hi_next            = ram_rdata.payload_hi;
                        out_seq_next           = ram_rdata.seq;
                        out_fresh_next         = pending_reg[slot_reg];
                        pending_next[slot_reg] = 1'b0;
                    end
                    else
                    begin
                        out_status_next = STAT_NOTHING;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pending_reg   <= '0;
            holds_reg     <= '0;
            seq_reg       <= '0;
            rr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            holds_reg     <= holds_next;
            seq_reg       <= seq_next;
            rr_reg        <= rr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_type_reg <= req.req_type;
            item_id_reg   <= req.frame_id;
            item_len_reg  <= req.frame_len;
            item_lo_reg   <= req.payload_lo;
            item_hi_reg   <= req.payload_hi;
            item_now_reg  <= req.now_ms;
            slot_reg      <= rd_addr;
            hit_reg       <= match_hit;
        end
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_len_reg    <= out_len_next;
        out_lo_reg     <= out_lo_next;
        out_hi_reg     <= out_hi_next;
        out_seq_reg    <= out_seq_next;
        out_fresh_reg  <= out_fresh_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.out_id         = out_id_reg;
    assign rsp.out_len        = out_len_reg;
    assign rsp.out_payload_lo = out_lo_reg;
    assign rsp.out_payload_hi = out_hi_reg;
    assign rsp.out_seq        = out_seq_reg;
    assign rsp.out_fresh      = out_fresh_reg;

    a_accept_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_RESP)
        else $error("accepted item did not move to update step");

    a_pending_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg & ~holds_reg) == '0)
        else $error("slot pending without stored data");

    a_write_only_frame: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_RESP && item_type_reg == REQ_FRAME && hit_reg))
        else $error("slot memory written outside a queued frame");

    a_rr_range: assert property (@(posedge clk) disable iff (!rst_n)
        rr_reg <= LAST_SLOT)
        else $error("round robin pointer out of range");

    a_zero_unless_sent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != STAT_SENT) |->
            (out_seq_reg == '0 && out_fresh_reg == 1'b0 && out_id_reg == '0))
        else $error("result fields not cleared for non-send status");

endmodule
